// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker modules of this block.
// Needs nothing else; each use names its clock and a message, and the plain check also its reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication check, switched off while reset is low
`define SIP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that must also hold while reset is low
`define SIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sip_pkg.sv =====
// Shared types, constants and saturation helper for the segment intersection unit.
// No dependencies; the interfaces, the top level and the checker take names from here by scope.
package sip_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SAT_W         = 72;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_OUTSIDE  = 2'd2,
		ST_DEGEN    = 2'd3
	} status_t;

	// Data carried alongside the slope dividers
	typedef struct packed {
		logic               degen;
		logic               sgn_a;
		logic signed [31:0] ax0;
		logic signed [31:0] ax1;
		logic signed [31:0] bx0;
		logic signed [31:0] bx1;
		logic signed [31:0] ay0;
		logic signed [31:0] by0;
	} line_pl_t;

	// Data carried alongside the abscissa divider
	typedef struct packed {
		status_t            st;
		logic               sgn;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] ax0;
		logic signed [31:0] ax1;
		logic signed [31:0] bx0;
		logic signed [31:0] bx1;
	} x_pl_t;

	// Clamp a wide signed value into 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > $signed({{(SAT_W-32){1'b0}}, 32'h7FFF_FFFF}))
			r = 32'sh7FFF_FFFF;
		else if (v < $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000}))
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/sip_if.sv =====
// Request channels of the segment intersection unit: segment pair in, result out.
// Depends on sip_pkg for the status type.
interface sip_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_start_x;
	logic signed [31:0] first_start_y;
	logic signed [31:0] first_end_x;
	logic signed [31:0] first_end_y;
	logic signed [31:0] second_start_x;
	logic signed [31:0] second_start_y;
	logic signed [31:0] second_end_x;
	logic signed [31:0] second_end_y;

	modport source (
		output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		output second_start_x, second_start_y, second_end_x, second_end_y,
		input  ready
	);
	modport sink (
		input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
		input  second_start_x, second_start_y, second_end_x, second_end_y,
		output ready
	);
endinterface

interface sip_out_if;
	logic               valid;
	logic               ready;
	sip_pkg::status_t   status;
	logic signed [31:0] cross_x;
	logic signed [31:0] cross_y;

	modport source (output valid, status, cross_x, cross_y, input ready);
	modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface

// ===== rtl/core/segment_intersection_point_unit.sv =====
// Segment intersection unit: takes a pair of segments (four signed fixed-point
// endpoints) on the pair channel and returns one result on the result channel:
// status (hit, parallel, outside, degenerate) and the crossing point, which is
// zero for every status but hit. tol_we/tol_wdata write the tolerance register
// (reset value 1); the user must drive them only while nothing is in flight,
// as the block itself does not enforce it. Throughput: one pair per clock,
// back to back, while the receiver is not holding the result. Each pair passes
// through the two bit-per-stage dividers: the slope dividers and, after them,
// the abscissa divider, each 32+FRAC_BITS stages.
// The whole pipeline moves as one: when the result is held by the receiver,
// every stage holds and pair.ready drops in the same cycle, so nothing is
// lost or repeated. Reset clears all valid bits and loads the tolerance with 1.
// Depends on sip_pkg, sip_if and sip_div.
module segment_intersection_point_unit #(
	parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tol_we,
	input  logic [15:0]   tol_wdata,
	sip_in_if.sink        pair,
	sip_out_if.source     result
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int XW = NW + 1;

	logic        en;
	logic [15:0] tol_q;

	// pipeline advances whenever the output slot is free or being taken
	assign en         = !result.valid || result.ready;
	assign pair.ready = en;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd1;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// saturate a signed quotient given as sign and magnitude
	function automatic logic signed [31:0] sat_q(input logic sgn, input logic [NW-1:0] q);
		logic signed [31:0] r;
		if (!sgn)
			r = (q > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
		else
			r = (q > NW'(64'h8000_0000)) ? 32'sh8000_0000 : -q[31:0];
		return r;
	endfunction

	// valid bits of the stages outside the dividers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	logic va_div, vx_div;

	// s1: input capture
	logic signed [31:0] ax0_s1, ay0_s1, ax1_s1, ay1_s1;
	logic signed [31:0] bx0_s1, by0_s1, bx1_s1, by1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s1 <= pair.first_start_x;
			ay0_s1 <= pair.first_start_y;
			ax1_s1 <= pair.first_end_x;
			ay1_s1 <= pair.first_end_y;
			bx0_s1 <= pair.second_start_x;
			by0_s1 <= pair.second_start_y;
			bx1_s1 <= pair.second_end_x;
			by1_s1 <= pair.second_end_y;
		end
	end

	// s2: differences, magnitudes and signs for the slope divisions
	logic signed [32:0] dxa_c, dya_c, dxb_c, dyb_c;
	logic        [32:0] mdxa_c, mdya_c, mdxb_c, mdyb_c;
	logic [NW-1:0]      numa_s2, numb_s2;
	logic [31:0]        dena_s2, denb_s2;
	sip_pkg::line_pl_t  pla_s2;
	logic               sgnb_s2;

	assign dxa_c  = {ax1_s1[31], ax1_s1} - {ax0_s1[31], ax0_s1};
	assign dya_c  = {ay1_s1[31], ay1_s1} - {ay0_s1[31], ay0_s1};
	assign dxb_c  = {bx1_s1[31], bx1_s1} - {bx0_s1[31], bx0_s1};
	assign dyb_c  = {by1_s1[31], by1_s1} - {by0_s1[31], by0_s1};
	assign mdxa_c = dxa_c[32] ? -dxa_c : dxa_c;
	assign mdya_c = dya_c[32] ? -dya_c : dya_c;
	assign mdxb_c = dxb_c[32] ? -dxb_c : dxb_c;
	assign mdyb_c = dyb_c[32] ? -dyb_c : dyb_c;

	always_ff @(posedge clk) begin
		if (en) begin
			numa_s2      <= {mdya_c[31:0], {FRAC_BITS{1'b0}}};
			numb_s2      <= {mdyb_c[31:0], {FRAC_BITS{1'b0}}};
			dena_s2      <= mdxa_c[31:0];
			denb_s2      <= mdxb_c[31:0];
			pla_s2.degen <= (ax0_s1 == ax1_s1) || (bx0_s1 == bx1_s1);
			pla_s2.sgn_a <= dya_c[32] ^ dxa_c[32];
			pla_s2.ax0   <= ax0_s1;
			pla_s2.ax1   <= ax1_s1;
			pla_s2.bx0   <= bx0_s1;
			pla_s2.bx1   <= bx1_s1;
			pla_s2.ay0   <= ay0_s1;
			pla_s2.by0   <= by0_s1;
			sgnb_s2      <= dyb_c[32] ^ dxb_c[32];
		end
	end

	// slope dividers
	logic [NW-1:0]     qa_div, qb_div;
	sip_pkg::line_pl_t pla_div;
	logic              sgnb_div;

	sip_div #(.NW(NW), .DW(32), .PW($bits(sip_pkg::line_pl_t))) u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .in_num(numa_s2), .in_den(dena_s2), .in_pl(pla_s2),
		.out_valid(va_div), .out_quo(qa_div), .out_pl(pla_div)
	);

	sip_div #(.NW(NW), .DW(32), .PW(1)) u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .in_num(numb_s2), .in_den(denb_s2), .in_pl(sgnb_s2),
		.out_valid(), .out_quo(qb_div), .out_pl(sgnb_div)
	);

	// s3: saturated slopes
	logic signed [31:0] a_s3, c_s3;
	sip_pkg::line_pl_t  pl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= sat_q(pla_div.sgn_a, qa_div);
			c_s3  <= sat_q(sgnb_div, qb_div);
			pl_s3 <= pla_div;
		end
	end

	// s4: slope times start abscissa
	logic signed [63:0] pa_s4, pc_s4;
	logic signed [31:0] a_s4, c_s4;
	sip_pkg::line_pl_t  pl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4 <= a_s3 * pl_s3.ax0;
			pc_s4 <= c_s3 * pl_s3.bx0;
			a_s4  <= a_s3;
			c_s4  <= c_s3;
			pl_s4 <= pl_s3;
		end
	end

	// s5: scale products back, truncating toward zero
	logic signed [63:0] ta_s5, tc_s5;
	logic signed [31:0] a_s5, c_s5;
	sip_pkg::line_pl_t  pl_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s5 <= $signed(pa_s4 + {{(64-FRAC_BITS){1'b0}}, {FRAC_BITS{pa_s4[63]}}})
				>>> FRAC_BITS;
			tc_s5 <= $signed(pc_s4 + {{(64-FRAC_BITS){1'b0}}, {FRAC_BITS{pc_s4[63]}}})
				>>> FRAC_BITS;
			a_s5  <= a_s4;
			c_s5  <= c_s4;
			pl_s5 <= pl_s4;
		end
	end

	// s6: intercepts
	logic signed [sip_pkg::SAT_W-1:0] bw_c, dw_c;
	logic signed [31:0] a_s6, b_s6, c_s6, d_s6;
	sip_pkg::line_pl_t  pl_s6;

	assign bw_c = {{(sip_pkg::SAT_W-32){pl_s5.ay0[31]}}, pl_s5.ay0}
		- {{(sip_pkg::SAT_W-64){ta_s5[63]}}, ta_s5};
	assign dw_c = {{(sip_pkg::SAT_W-32){pl_s5.by0[31]}}, pl_s5.by0}
		- {{(sip_pkg::SAT_W-64){tc_s5[63]}}, tc_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			a_s6  <= a_s5;
			c_s6  <= c_s5;
			b_s6  <= sip_pkg::sat32(bw_c);
			d_s6  <= sip_pkg::sat32(dw_c);
			pl_s6 <= pl_s5;
		end
	end

	// s7: slope and intercept differences
	logic signed [32:0] den_s7, nm_s7;
	logic signed [31:0] a_s7, b_s7;
	sip_pkg::line_pl_t  pl_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7 <= {a_s6[31], a_s6} - {c_s6[31], c_s6};
			nm_s7  <= {d_s6[31], d_s6} - {b_s6[31], b_s6};
			a_s7   <= a_s6;
			b_s7   <= b_s6;
			pl_s7  <= pl_s6;
		end
	end

	// s8: magnitudes, parallel test, early status
	logic [32:0]       mden_c, mnm_c;
	logic [NW-1:0]     numx_s8;
	logic [31:0]       denx_s8;
	sip_pkg::x_pl_t    px_s8;
	sip_pkg::status_t  st_c;

	assign mden_c = den_s7[32] ? -den_s7 : den_s7;
	assign mnm_c  = nm_s7[32] ? -nm_s7 : nm_s7;

	always_comb begin
		if (pl_s7.degen)
			st_c = sip_pkg::ST_DEGEN;
		else if ((den_s7 == '0) || (mden_c < {17'd0, tol_q}))
			st_c = sip_pkg::ST_PARALLEL;
		else
			st_c = sip_pkg::ST_HIT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s8   <= {mnm_c[31:0], {FRAC_BITS{1'b0}}};
			denx_s8   <= mden_c[31:0];
			px_s8.st  <= st_c;
			px_s8.sgn <= den_s7[32] ^ nm_s7[32];
			px_s8.a   <= a_s7;
			px_s8.b   <= b_s7;
			px_s8.ax0 <= pl_s7.ax0;
			px_s8.ax1 <= pl_s7.ax1;
			px_s8.bx0 <= pl_s7.bx0;
			px_s8.bx1 <= pl_s7.bx1;
		end
	end

	// abscissa divider
	logic [NW-1:0]  qx_div;
	sip_pkg::x_pl_t px_div;

	sip_div #(.NW(NW), .DW(32), .PW($bits(sip_pkg::x_pl_t))) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s8), .in_num(numx_s8), .in_den(denx_s8), .in_pl(px_s8),
		.out_valid(vx_div), .out_quo(qx_div), .out_pl(px_div)
	);

	// s9: signed abscissa
	logic signed [XW-1:0] x_s9;
	sip_pkg::x_pl_t       px_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s9  <= px_div.sgn ? -{1'b0, qx_div} : {1'b0, qx_div};
			px_s9 <= px_div;
		end
	end

	// s10: span comparisons and distances to start abscissae
	logic signed [XW-1:0] eax0_c, eax1_c, ebx0_c, ebx1_c;
	logic signed [XW:0]   da_s10, db_s10;
	logic                 lt_a_s10, gt_a_s10, lt_b_s10, gt_b_s10;
	logic signed [XW-1:0] x_s10;
	sip_pkg::x_pl_t       px_s10;

	assign eax0_c = {{(XW-32){px_s9.ax0[31]}}, px_s9.ax0};
	assign eax1_c = {{(XW-32){px_s9.ax1[31]}}, px_s9.ax1};
	assign ebx0_c = {{(XW-32){px_s9.bx0[31]}}, px_s9.bx0};
	assign ebx1_c = {{(XW-32){px_s9.bx1[31]}}, px_s9.bx1};

	always_ff @(posedge clk) begin
		if (en) begin
			da_s10   <= {x_s9[XW-1], x_s9} - {eax0_c[XW-1], eax0_c};
			db_s10   <= {x_s9[XW-1], x_s9} - {ebx0_c[XW-1], ebx0_c};
			lt_a_s10 <= (x_s9 < eax0_c) && (x_s9 < eax1_c);
			gt_a_s10 <= (x_s9 > eax0_c) && (x_s9 > eax1_c);
			lt_b_s10 <= (x_s9 < ebx0_c) && (x_s9 < ebx1_c);
			gt_b_s10 <= (x_s9 > ebx0_c) && (x_s9 > ebx1_c);
			x_s10    <= x_s9;
			px_s10   <= px_s9;
		end
	end

	// s11: outside test and final status
	logic [XW:0]        mda_c, mdb_c;
	logic               out_a_c, out_b_c;
	sip_pkg::status_t   st_s11;
	logic signed [33:0] xc_s11;
	logic signed [31:0] ox_s11, a_s11, b_s11;

	assign mda_c   = da_s10[XW] ? -da_s10 : da_s10;
	assign mdb_c   = db_s10[XW] ? -db_s10 : db_s10;
	assign out_a_c = (mda_c >= {{(XW-15){1'b0}}, tol_q}) && (lt_a_s10 || gt_a_s10);
	assign out_b_c = (mdb_c >= {{(XW-15){1'b0}}, tol_q}) && (lt_b_s10 || gt_b_s10);

	always_ff @(posedge clk) begin
		if (en) begin
			if (px_s10.st == sip_pkg::ST_HIT && (out_a_c || out_b_c))
				st_s11 <= sip_pkg::ST_OUTSIDE;
			else
				st_s11 <= px_s10.st;
			// a hit keeps x within a span plus tolerance, so 34 bits suffice
			xc_s11 <= x_s10[33:0];
			ox_s11 <= sip_pkg::sat32({{(sip_pkg::SAT_W-XW){x_s10[XW-1]}}, x_s10});
			a_s11  <= px_s10.a;
			b_s11  <= px_s10.b;
		end
	end

	// s12: split product a*x into two partial products
	logic signed [49:0] pl_s12;
	logic signed [48:0] ph_s12;
	sip_pkg::status_t   st_s12;
	logic signed [31:0] ox_s12, b_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s12 <= a_s11 * $signed({1'b0, xc_s11[16:0]});
			ph_s12 <= a_s11 * $signed(xc_s11[33:17]);
			st_s12 <= st_s11;
			ox_s12 <= ox_s11;
			b_s12  <= b_s11;
		end
	end

	// s13: combine partial products
	logic signed [65:0] p_s13;
	sip_pkg::status_t   st_s13;
	logic signed [31:0] ox_s13, b_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s13  <= {ph_s12, 17'd0} + {{16{pl_s12[49]}}, pl_s12};
			st_s13 <= st_s12;
			ox_s13 <= ox_s12;
			b_s13  <= b_s12;
		end
	end

	// s14: scale back, truncating toward zero
	logic signed [65:0] t_s14;
	sip_pkg::status_t   st_s14;
	logic signed [31:0] ox_s14, b_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s14  <= $signed(p_s13 + {{(66-FRAC_BITS){1'b0}}, {FRAC_BITS{p_s13[65]}}})
				>>> FRAC_BITS;
			st_s14 <= st_s13;
			ox_s14 <= ox_s13;
			b_s14  <= b_s13;
		end
	end

	// s15: output register
	logic signed [sip_pkg::SAT_W-1:0] yw_c;
	sip_pkg::status_t   st_s15;
	logic signed [31:0] cx_s15, cy_s15;

	assign yw_c = {{(sip_pkg::SAT_W-66){t_s14[65]}}, t_s14}
		+ {{(sip_pkg::SAT_W-32){b_s14[31]}}, b_s14};

	always_ff @(posedge clk) begin
		if (en) begin
			st_s15 <= st_s14;
			cx_s15 <= (st_s14 == sip_pkg::ST_HIT) ? ox_s14 : 32'sd0;
			cy_s15 <= (st_s14 == sip_pkg::ST_HIT) ? sip_pkg::sat32(yw_c) : 32'sd0;
		end
	end

	assign result.valid   = v_s15;
	assign result.status  = st_s15;
	assign result.cross_x = cx_s15;
	assign result.cross_y = cy_s15;

	// valid bits of the stages outside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s1  <= pair.valid;
			v_s2  <= v_s1;
			v_s3  <= va_div;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= vx_div;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

endmodule

// ===== rtl/core/sip_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with side data.
// Standalone; used by the top level for slopes and for the crossing abscissa.
module sip_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pl,
	output logic          out_valid,
	output logic [NW-1:0] out_quo,
	output logic [PW-1:0] out_pl
);

	logic          v   [0:NW];
	logic [DW-1:0] rem [0:NW];
	logic [NW-1:0] nq  [0:NW];
	logic [DW-1:0] den [0:NW];
	logic [PW-1:0] pl  [0:NW];

	// stage zero is the request itself
	assign v[0]   = in_valid;
	assign rem[0] = '0;
	assign nq[0]  = in_num;
	assign den[0] = in_den;
	assign pl[0]  = in_pl;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] cat;
		logic [DW:0] trial;

		// shift in next dividend bit, try to subtract the divisor
		assign cat   = {rem[k], nq[k][NW-1]};
		assign trial = cat - {1'b0, den[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[k+1] <= 1'b0;
			end else if (en) begin
				v[k+1] <= v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= trial[DW] ? cat[DW-1:0] : trial[DW-1:0];
				nq[k+1]  <= {nq[k][NW-2:0], ~trial[DW]};
				den[k+1] <= den[k];
				pl[k+1]  <= pl[k];
			end
		end
	end

	assign out_valid = v[NW];
	assign out_quo   = nq[NW];
	assign out_pl    = pl[NW];

endmodule

// ===== rtl/core/sip_chk.sv =====
// Port-level checker for the segment intersection unit, bound to the top level.
// Depends on assert_macros.svh and sip_pkg.
`include "assert_macros.svh"

module sip_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input sip_pkg::status_t   status,
	input logic signed [31:0] cross_x,
	input logic signed [31:0] cross_y
);

	// a held result keeps its request up
	`SIP_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// a held result keeps its payload
	`SIP_ASSERT(a_out_stable, clk, arst_n, $past(out_valid && !out_ready) |-> $stable(status) && $stable(cross_x) && $stable(cross_y), "result changed while stalled")

	// the pipeline stops taking pairs exactly when the output is blocked
	`SIP_ASSERT(a_in_ready, clk, arst_n, in_ready == (!out_valid || out_ready), "pair ready does not follow output stall")

	// only a hit carries a point
	`SIP_ASSERT(a_zero_miss, clk, arst_n, out_valid && status != sip_pkg::ST_HIT |-> cross_x == 32'sd0 && cross_y == 32'sd0, "point given for a miss")

	// nothing comes out in the cycle after reset is seen low, unless reset has been released
	`SIP_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid || arst_n, "result valid out of reset")

endmodule

bind segment_intersection_point_unit sip_chk u_sip_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pair.valid),
	.in_ready  (pair.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.status    (result.status),
	.cross_x   (result.cross_x),
	.cross_y   (result.cross_y)
);
